/* hw/rtl/kst_pkg.sv */
// Shared types and constants for the keyed slot table with LRU replacement.
package kst_pkg;

  localparam int unsigned DIR_W   = 8;
  localparam int unsigned ICON_W  = 3;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned INDEX_W = 4;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  typedef enum logic [1:0] {
    OUTCOME_CLEARED = 2'd0,
    OUTCOME_UPDATED = 2'd1,
    OUTCOME_FILLED  = 2'd2,
    OUTCOME_EVICTED = 2'd3
  } outcome_e;

  typedef struct packed {
    logic              op;
    logic [DIR_W-1:0]  direction;
    logic [ICON_W-1:0] icon;
  } in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] slot_index;
    logic [1:0]         outcome;
    logic [DIR_W-1:0]   evicted_direction;
    logic [ICON_W-1:0]  evicted_icon;
  } out_t;

  typedef struct packed {
    logic [DIR_W-1:0]   direction;
    logic [ICON_W-1:0]  icon;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

/* hw/rtl/kst_slot_mem.sv */
// Slot memory: one synchronous read port, one write port, per-slot valid flops.
module kst_slot_mem #(
  parameter int unsigned SLOTS = 4,
  parameter int unsigned IDX_W = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clr_i,
  input  logic                 rd_en_i,
  input  logic [IDX_W-1:0]     rd_addr_i,
  output logic                 rd_valid_o,
  output kst_pkg::entry_t      rd_entry_o,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_addr_i,
  input  kst_pkg::entry_t      wr_entry_i
);
  import kst_pkg::*;

  entry_t           mem_q [SLOTS];
  logic [SLOTS-1:0] valid_q;
  entry_t           rd_data_q;
  logic             rd_vld_q;

  // Valid bits: clear resets all slots at once, write sets one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_i) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
      rd_vld_q  <= valid_q[rd_addr_i];
    end
  end

  // An empty slot reads as all zeros.
  assign rd_valid_o = rd_vld_q;
  assign rd_entry_o = rd_vld_q ? rd_data_q : '0;

endmodule

/* hw/rtl/kst_engine.sv */
// Command sequencer: scans the slot memory, picks the target slot, writes it back.
module kst_engine #(
  parameter int unsigned SLOTS = 4,
  parameter int unsigned IDX_W = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  kst_pkg::in_t         in_data_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output kst_pkg::out_t        res_o,
  output logic                 clr_o,
  output logic                 rd_en_o,
  output logic [IDX_W-1:0]     rd_addr_o,
  input  logic                 rd_valid_i,
  input  kst_pkg::entry_t      rd_entry_i,
  output logic                 wr_en_o,
  output logic [IDX_W-1:0]     wr_addr_o,
  output kst_pkg::entry_t      wr_entry_o
);
  import kst_pkg::*;

  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_HOLD
  } state_e;

  state_e               state_q, state_d;
  in_t                  cmd_q, cmd_d;
  logic [STAMP_W-1:0]   counter_q, counter_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 match_q, match_d;
  logic [IDX_W-1:0]     match_idx_q, match_idx_d;
  logic                 free_q, free_d;
  logic [IDX_W-1:0]     free_idx_q, free_idx_d;
  logic [STAMP_W-1:0]   min_stamp_q, min_stamp_d;
  logic [IDX_W-1:0]     min_idx_q, min_idx_d;
  logic [DIR_W-1:0]     min_dir_q, min_dir_d;
  logic [ICON_W-1:0]    min_icon_q, min_icon_d;
  out_t                 res_q, res_d;

  logic [CNT_W-1:0]     cnt_m1;
  logic [IDX_W-1:0]     ev_idx;
  logic [IDX_W-1:0]     tgt_idx;

  assign cnt_m1 = cnt_q - CNT_W'(1);
  assign ev_idx = cnt_m1[IDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    counter_d   = counter_q;
    cnt_d       = cnt_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    min_stamp_d = min_stamp_q;
    min_idx_d   = min_idx_q;
    min_dir_d   = min_dir_q;
    min_icon_d  = min_icon_q;
    res_d       = res_q;
    clr_o       = 1'b0;
    rd_en_o     = 1'b0;
    rd_addr_o   = cnt_q[IDX_W-1:0];
    wr_en_o     = 1'b0;
    tgt_idx     = min_idx_q;
    wr_addr_o   = tgt_idx;
    wr_entry_o  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = in_data_i;
          counter_d = counter_q + STAMP_W'(1);
          if (in_data_i.op == OP_CLEAR) begin
            clr_o   = 1'b1;
            res_d   = '0;
            res_d.outcome = OUTCOME_CLEARED;
            state_d = S_HOLD;
          end else begin
            cnt_d   = '0;
            match_d = 1'b0;
            free_d  = 1'b0;
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one read per cycle; judge the slot read in the previous cycle.
        if (cnt_q < CNT_W'(SLOTS)) begin
          rd_en_o = 1'b1;
        end
        if (cnt_q != '0) begin
          if (!match_q && rd_valid_i && rd_entry_i.direction == cmd_q.direction) begin
            match_d     = 1'b1;
            match_idx_d = ev_idx;
          end
          if (!rd_valid_i) begin
            free_d     = 1'b1;
            free_idx_d = ev_idx;
          end
          if (cnt_q == CNT_W'(1) || rd_entry_i.stamp < min_stamp_q) begin
            min_stamp_d = rd_entry_i.stamp;
            min_idx_d   = ev_idx;
            min_dir_d   = rd_entry_i.direction;
            min_icon_d  = rd_entry_i.icon;
          end
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SLOTS)) begin
          state_d = S_WRITE;
        end
      end

      S_WRITE: begin
        res_d = '0;
        if (match_q) begin
          tgt_idx       = match_idx_q;
          res_d.outcome = OUTCOME_UPDATED;
        end else if (free_q) begin
          tgt_idx       = free_idx_q;
          res_d.outcome = OUTCOME_FILLED;
        end else begin
          tgt_idx                 = min_idx_q;
          res_d.outcome           = OUTCOME_EVICTED;
          res_d.evicted_direction = min_dir_q;
          res_d.evicted_icon      = min_icon_q;
        end
        res_d.slot_index     = INDEX_W'(tgt_idx);
        wr_en_o              = 1'b1;
        wr_addr_o            = tgt_idx;
        wr_entry_o.direction = cmd_q.direction;
        wr_entry_o.icon      = cmd_q.icon;
        wr_entry_o.stamp     = counter_q;
        state_d              = S_HOLD;
      end

      S_HOLD: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      counter_q <= '0;
    end else begin
      state_q   <= state_d;
      counter_q <= counter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    cnt_q       <= cnt_d;
    match_q     <= match_d;
    match_idx_q <= match_idx_d;
    free_q      <= free_d;
    free_idx_q  <= free_idx_d;
    min_stamp_q <= min_stamp_d;
    min_idx_q   <= min_idx_d;
    min_dir_q   <= min_dir_d;
    min_icon_q  <= min_icon_d;
    res_q       <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_HOLD);
  assign res_o       = res_q;

endmodule

/* hw/rtl/keyed_slot_table_lru_replace.sv */
// Top level of the keyed slot table with least-recently-used replacement.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one command per
// transaction: clear all slots, or place an icon under a direction key.
// Output channel (out_valid_o / out_ready_i / out_data_o) returns exactly one
// result transaction per command: slot written, outcome, evicted key and icon.
//
// Slot contents live in a small synchronous memory with a registered read
// port. A place command reads every slot in turn, one read per cycle with
// the compare of each slot in the cycle after its read, then writes the
// chosen slot back. A clear drops all valid bits at once. The next command
// is taken only after the previous write-back, so a scan never races its
// write.
//
// Reset drops all valid bits and the use counter; an empty slot reads as
// zero, so no clearing pass is needed. Results pass through an output
// register: while the receiver stalls, the sequencer can take and process
// one more command, then holds its result until the register frees up.
module keyed_slot_table_lru_replace #(
  parameter int unsigned SLOTS = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  kst_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output kst_pkg::out_t out_data_o
);
  import kst_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Sequencer <-> memory
  logic             clr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_valid;
  entry_t           rd_entry;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_entry;

  // Sequencer -> output register
  logic res_valid;
  logic res_ready;
  out_t res;

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  kst_slot_mem #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (clr),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_valid_o (rd_valid),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry)
  );

  kst_engine #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .clr_o       (clr),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_valid_i  (rd_valid),
    .rd_entry_i  (rd_entry),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_entry_o  (wr_entry)
  );

  // Output register: load when empty or draining in the same cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* test/tb_top.sv */
// Testbench for keyed_slot_table_lru_replace: directed and random commands checked against a model.
module tb_top;
  import kst_pkg::*;

  localparam int unsigned SLOTS       = 4;
  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned IDLE_PCT    = 23;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Stimulus side of the input channel.
  logic in_valid = 1'b0;
  in_t  in_data  = '0;
  logic in_ready;
  bit   offering = 1'b0;   // mirrors in_valid without waiting for the NBA

  // Response side of the output channel.
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Test control shared between the initial block and the channel processes.
  bit steady       = 1'b0;  // suppress random idling on both channels
  int hold_request = 0;     // ask the receiver for a long stall, in cycles
  int hold_left    = 0;

  int err_count    = 0;
  int result_count = 0;
  int cycle_count  = 0;

  // Predicted table contents and use counter.
  logic                 tbl_valid [SLOTS];
  logic [DIR_W-1:0]     tbl_dir   [SLOTS];
  logic [ICON_W-1:0]    tbl_icon  [SLOTS];
  logic [STAMP_W-1:0]   tbl_stamp [SLOTS];
  logic [STAMP_W-1:0]   use_count;

  // Results predicted for accepted commands, oldest first.
  out_t pending_results[$];
  out_t want_res;

  keyed_slot_table_lru_replace #(
    .SLOTS(SLOTS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("keyed_slot_table_lru_replace verification failed");
      $finish;
    end
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input int got, input int exp);
    $display("MISMATCH result %0d %s: got %0d expected %0d", result_count, what, got, exp);
    err_count++;
  endtask

  // Apply one command to the predicted table and return the result it yields.
  function automatic out_t table_apply(input in_t cmd);
    out_t res;
    int   hit;
    int   vacant;
    int   oldest;
    int   pick;
    res    = '0;
    hit    = -1;
    vacant = -1;
    oldest = 0;
    // Every command bumps the counter first, clears included.
    use_count = use_count + STAMP_W'(1);
    if (cmd.op == OP_CLEAR) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_dir[i]   = '0;
        tbl_icon[i]  = '0;
        tbl_stamp[i] = '0;
      end
      res.outcome = OUTCOME_CLEARED;
      return res;
    end
    // Stop at the first live key match; otherwise remember the highest free
    // slot and the lowest-numbered slot holding the smallest stamp.
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i] && tbl_dir[i] == cmd.direction) begin
        hit = i;
        break;
      end
      if (!tbl_valid[i]) vacant = i;
      if (tbl_stamp[i] < tbl_stamp[oldest]) oldest = i;
    end
    if (hit >= 0) begin
      pick        = hit;
      res.outcome = OUTCOME_UPDATED;
    end else if (vacant >= 0) begin
      pick        = vacant;
      res.outcome = OUTCOME_FILLED;
    end else begin
      pick                  = oldest;
      res.outcome           = OUTCOME_EVICTED;
      res.evicted_direction = tbl_dir[pick];
      res.evicted_icon      = tbl_icon[pick];
    end
    tbl_valid[pick] = 1'b1;
    tbl_dir[pick]   = cmd.direction;
    tbl_icon[pick]  = cmd.icon;
    tbl_stamp[pick] = use_count;
    res.slot_index  = pick[INDEX_W-1:0];
    return res;
  endfunction

  function automatic in_t make_cmd(input logic op, input int dir, input int icon);
    in_t cmd;
    cmd.op        = op;
    cmd.direction = dir[DIR_W-1:0];
    cmd.icon      = icon[ICON_W-1:0];
    return cmd;
  endfunction

  // Offer one command, optionally after a random gap, and hold it until the
  // transaction completes; then record its predicted result.
  task automatic send_cmd(input in_t cmd);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      if (offering) begin
        in_valid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_ready);
    pending_results.push_back(table_apply(cmd));
  endtask

  // Drop valid and wait until every outstanding result has been seen.
  task automatic drain_results();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Receiver: random stalls, a requested long stall, or always ready.
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Check every completed output transaction against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, outcome", int'(out_data.outcome), -1);
      end else begin
        want_res = pending_results.pop_front();
        if (out_data.slot_index !== want_res.slot_index)
          report_mismatch("slot_index", int'(out_data.slot_index),
                          int'(want_res.slot_index));
        if (out_data.outcome !== want_res.outcome)
          report_mismatch("outcome", int'(out_data.outcome), int'(want_res.outcome));
        if (out_data.evicted_direction !== want_res.evicted_direction)
          report_mismatch("evicted_direction", int'(out_data.evicted_direction),
                          int'(want_res.evicted_direction));
        if (out_data.evicted_icon !== want_res.evicted_icon)
          report_mismatch("evicted_icon", int'(out_data.evicted_icon),
                          int'(want_res.evicted_icon));
      end
    end
  end

  // Field extremes, clear with junk fields, fill order, update and eviction.
  task automatic test_field_corners();
    send_cmd(make_cmd(OP_CLEAR, 255, 7));
    send_cmd(make_cmd(OP_PLACE, 0, 0));     // fills the highest free slot
    send_cmd(make_cmd(OP_PLACE, 255, 7));
    send_cmd(make_cmd(OP_PLACE, 0, 5));     // key hit: update in place
    send_cmd(make_cmd(OP_PLACE, 128, 6));
    send_cmd(make_cmd(OP_PLACE, 127, 1));   // last free slot
    send_cmd(make_cmd(OP_PLACE, 85, 2));    // table full: evict oldest
    send_cmd(make_cmd(OP_PLACE, 170, 3));
    send_cmd(make_cmd(OP_PLACE, 255, 4));
    send_cmd(make_cmd(OP_CLEAR, 0, 0));
    send_cmd(make_cmd(OP_PLACE, 1, 0));     // after clear, back to the top slot
  endtask

  // Touch entries out of order so the eviction victim moves around.
  task automatic test_lru_order();
    send_cmd(make_cmd(OP_CLEAR, 170, 5));
    send_cmd(make_cmd(OP_PLACE, 10, 1));
    send_cmd(make_cmd(OP_PLACE, 20, 2));
    send_cmd(make_cmd(OP_PLACE, 30, 3));
    send_cmd(make_cmd(OP_PLACE, 40, 4));
    send_cmd(make_cmd(OP_PLACE, 10, 6));    // refresh the oldest entry
    send_cmd(make_cmd(OP_PLACE, 30, 7));
    send_cmd(make_cmd(OP_PLACE, 50, 0));    // victim is key 20
    send_cmd(make_cmd(OP_PLACE, 60, 1));    // victim is key 40
    send_cmd(make_cmd(OP_PLACE, 70, 2));
    send_cmd(make_cmd(OP_PLACE, 20, 3));
    drain_results();
  endtask

  // Stall the receiver long enough that the block backs up into its input.
  task automatic test_output_stall();
    steady       = 1'b1;
    hold_request = 150;
    for (int n = 0; n < 12; n++)
      send_cmd(make_cmd(OP_PLACE, int'($urandom_range(255) & 32'h0f),
                        int'($urandom_range(7))));
    steady = 1'b0;
    drain_results();
  endtask

  // Keyed traffic over small key sets so hits, fills and evictions all occur,
  // mixed with fully random keys and occasional clears.
  task automatic test_random_traffic(input int count, input bit no_idle);
    logic [DIR_W-1:0] keys[8];
    int               nkeys;
    int               roll;
    logic [2:0]       kidx;
    in_t              cmd;
    steady = no_idle;
    nkeys  = 1;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        nkeys = $urandom_range(3, 8);
        foreach (keys[k]) keys[k] = DIR_W'($urandom_range(255));
      end
      roll          = $urandom_range(99);
      kidx          = 3'($urandom_range(nkeys - 1));
      cmd.op        = OP_PLACE;
      cmd.icon      = ICON_W'($urandom_range(7));
      cmd.direction = keys[kidx];
      if (roll < 3) cmd.op = OP_CLEAR;
      else if (roll < 30) cmd.direction = DIR_W'($urandom_range(255));
      send_cmd(cmd);
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_dir[i]   = '0;
      tbl_icon[i]  = '0;
      tbl_stamp[i] = '0;
    end
    use_count = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_corners();
    test_lru_order();
    test_output_stall();
    test_random_traffic(200, 1'b1);
    test_random_traffic(1050, 1'b0);

    // Let the last results out, then keep the clock running to catch anything stray.
    drain_results();
    repeat (20) @(posedge clk_i);

    if (err_count == 0) begin
      $display("keyed_slot_table_lru_replace verification clean");
    end else begin
      $display("keyed_slot_table_lru_replace verification failed");
    end
    $finish;
  end

endmodule

/* keyed_slot_table_lru_replace.f */
hw/rtl/kst_pkg.sv
hw/rtl/kst_slot_mem.sv
hw/rtl/kst_engine.sv
hw/rtl/keyed_slot_table_lru_replace.sv
test/tb_top.sv
